/* hw/rtl/m3inv_pkg.sv */
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared constants for the 3x3 adjugate matrix inverter.
// ----------------------------------------------------------------------------
package m3inv_pkg;

  // default element format: signed Q16.16
  localparam int ELEM_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // determinant threshold register
  localparam int THR_WIDTH = 31;

  // configuration port
  localparam int APB_ADDR_WIDTH = 2;
  localparam int APB_DATA_WIDTH = 32;
  localparam logic [APB_ADDR_WIDTH-1:0] ADDR_DET_THRESHOLD = 2'd0;

  // items held between front and back
  localparam int QUEUE_DEPTH = 4;

endpackage

/* hw/rtl/m3inv_front.sv */
// ----------------------------------------------------------------------------
// m3inv_front
// Front pipeline: cofactors, exact determinant and classification.
// Five stages, one item per cycle; stalls only when the queue is full.
// ----------------------------------------------------------------------------
module m3inv_front #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [m3inv_pkg::THR_WIDTH-1:0]   det_threshold,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [9*ELEM_WIDTH-1:0]           in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  // fields from bit 0: cmag[0..8], csign[0..8], dabs, dsign, inv
  output logic [9*2*ELEM_WIDTH+9+3*ELEM_WIDTH+1:0] out_data
);
  import m3inv_pkg::*;

  localparam int W    = ELEM_WIDTH;
  localparam int PW   = 2 * W;           // element product
  localparam int CW   = 2 * W + 1;       // signed cofactor
  localparam int MW   = 2 * W;           // cofactor magnitude
  localparam int DW   = 3 * W + 1;       // signed determinant
  localparam int AW   = 3 * W;           // determinant magnitude
  localparam int TW   = THR_WIDTH + 2 * FRAC_BITS;
  localparam int CMPW = AW + TW;

  // cofactor k = m[X]*m[Y] - m[U]*m[V] (sign already folded in)
  localparam int COF_X [9] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_Y [9] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_U [9] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_V [9] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  logic en;
  logic v1, v2, v3, v4, v5;

  logic signed [W-1:0]  m     [9];
  logic signed [PW-1:0] s1_pa [9];
  logic signed [PW-1:0] s1_pb [9];
  logic signed [W-1:0]  s1_m  [3];
  logic signed [CW-1:0] s2_cof [9];
  logic signed [W-1:0]  s2_m  [3];
  logic signed [CW-1:0] s3_cof [9];
  logic signed [CW-1:0] s3_pl [3];
  logic signed [CW-1:0] s3_ph [3];
  logic signed [CW-1:0] s4_cof [9];
  logic signed [DW-1:0] s4_det;
  logic signed [DW-1:0] det_sum;
  logic [MW-1:0]        s5_cmag [9];
  logic [8:0]           s5_csign;
  logic [AW-1:0]        s5_dabs;
  logic                 s5_dsign;
  logic                 s5_inv;

  assign en        = !v5 || out_ready;
  assign in_ready  = en;
  assign out_valid = v5;

  // unpack elements, row-major
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      m[i] = $signed(in_data[i*W +: W]);
    end
  end

  // stage 1: the eighteen element products
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      for (int k = 0; k < 9; k++) begin
        s1_pa[k] <= m[COF_X[k]] * m[COF_Y[k]];
        s1_pb[k] <= m[COF_U[k]] * m[COF_V[k]];
      end
      for (int j = 0; j < 3; j++) begin
        s1_m[j] <= m[j];
      end
    end
  end

  // stage 2: cofactors
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
      for (int k = 0; k < 9; k++) begin
        s2_cof[k] <= CW'(s1_pa[k]) - CW'(s1_pb[k]);
      end
      s2_m <= s1_m;
    end
  end

  // stage 3: first-row terms, cofactor split in low and high halves
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
      s3_cof <= s2_cof;
      for (int j = 0; j < 3; j++) begin
        s3_pl[j] <= s2_m[j] * $signed({1'b0, s2_cof[3*j][W-1:0]});
        s3_ph[j] <= s2_m[j] * $signed(s2_cof[3*j][CW-1:W]);
      end
    end
  end

  // stage 4: determinant
  always_comb begin
    det_sum = '0;
    for (int j = 0; j < 3; j++) begin
      det_sum = det_sum + (DW'(s3_ph[j]) <<< W) + DW'(s3_pl[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
      s4_cof <= s3_cof;
      s4_det <= det_sum;
    end
  end

  // stage 5: magnitudes, signs and threshold test
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
      for (int k = 0; k < 9; k++) begin
        s5_csign[k] <= s4_cof[k][CW-1];
        s5_cmag[k]  <= s4_cof[k][CW-1] ? MW'(-s4_cof[k]) : MW'(s4_cof[k]);
      end
      s5_dsign <= s4_det[DW-1];
      s5_dabs  <= s4_det[DW-1] ? AW'(-s4_det) : AW'(s4_det);
      s5_inv   <= CMPW'(s4_det[DW-1] ? AW'(-s4_det) : AW'(s4_det))
                  > CMPW'({det_threshold, {(2*FRAC_BITS){1'b0}}});
    end
  end

  // pack for the queue
  always_comb begin
    out_data = '0;
    for (int k = 0; k < 9; k++) begin
      out_data[k*MW +: MW] = s5_cmag[k];
    end
    out_data[9*MW +: 9]        = s5_csign;
    out_data[9*MW+9 +: AW]     = s5_dabs;
    out_data[9*MW+9+AW]        = s5_dsign;
    out_data[9*MW+9+AW+1]      = s5_inv;
  end

endmodule

/* hw/rtl/m3inv_fifo.sv */
// ----------------------------------------------------------------------------
// m3inv_fifo
// Short register queue between front and back pipelines.
// ----------------------------------------------------------------------------
module m3inv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_data
);
  import m3inv_pkg::*;

  localparam int PTRW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTRW-1:0]  wptr, rptr;
  logic [CNTW-1:0]  count;
  logic             push, pop;

  assign in_ready  = (count != CNTW'(DEPTH));
  assign out_valid = (count != '0);
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_data  = mem[rptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= in_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PTRW'(DEPTH - 1)) ? '0 : wptr + PTRW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PTRW'(DEPTH - 1)) ? '0 : rptr + PTRW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNTW'(DEPTH))
    else $error("queue count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + CNTW'(1)))
    else $error("queue count did not grow on push");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - CNTW'(1)))
    else $error("queue count did not shrink on pop");

endmodule

/* hw/rtl/m3inv_back.sv */
// ----------------------------------------------------------------------------
// m3inv_back
// Back pipeline: nine restoring dividers, one quotient bit per stage,
// followed by saturation into the output register.
// ----------------------------------------------------------------------------
module m3inv_back #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [9*2*ELEM_WIDTH+9+3*ELEM_WIDTH+1:0] in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [9*ELEM_WIDTH-1:0]            out_data,
  output logic                               inverted,
  output logic                               saturated
);
  import m3inv_pkg::*;

  localparam int W  = ELEM_WIDTH;
  localparam int MW = 2 * W;
  localparam int AW = 3 * W;
  localparam int RW = 4 * W + 2 * FRAC_BITS;
  localparam logic [W-1:0] MAXP = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // {saturated, result} for magnitude v with sign ng
  function automatic logic [W:0] sat_fn(input logic [MW-1:0] v, input logic ng);
    logic         s;
    logic [W-1:0] r;
    if (!ng) begin
      s = (v > MW'(MAXP));
      r = s ? MAXP : v[W-1:0];
    end else begin
      s = (v > MW'(MINV));
      r = s ? MINV : (~v[W-1:0] + W'(1));
    end
    return {s, r};
  endfunction

  logic en;

  // per-stage state; stage 0 is the load stage
  logic            vld  [W+1];
  logic [RW-1:0]   rem  [W+1][9];
  logic [W-1:0]    quo  [W+1][9];
  logic            ovf  [W+1][9];
  logic            neg  [W+1][9];
  logic [AW-1:0]   dabs [W+1];
  logic            inv  [W+1];

  // next values of the division stages, indexed by the stage they read
  logic [RW-1:0]   trial [W];
  logic [RW-1:0]   nrem  [W][9];
  logic [W-1:0]    nquo  [W][9];

  // load-stage decode
  logic [MW-1:0]   ld_cmag  [9];
  logic [8:0]      ld_csign;
  logic [AW-1:0]   ld_dabs;
  logic            ld_dsign;
  logic            ld_inv;
  logic [RW-1:0]   ld_rem   [9];
  logic [W-1:0]    ld_quo   [9];
  logic            ld_ovf   [9];
  logic            ld_neg   [9];

  // output stage
  logic [W-1:0]    fin_res  [9];
  logic [8:0]      fin_sat;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;

  // load stage: numerator, overflow test, adjugate path finished here
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      ld_cmag[l] = in_data[l*MW +: MW];
    end
    ld_csign = in_data[9*MW +: 9];
    ld_dabs  = in_data[9*MW+9 +: AW];
    ld_dsign = in_data[9*MW+9+AW];
    ld_inv   = in_data[9*MW+9+AW+1];
    for (int l = 0; l < 9; l++) begin
      ld_rem[l] = RW'(ld_cmag[l]) << (2 * FRAC_BITS);
      if (ld_inv) begin
        ld_ovf[l] = (ld_rem[l] >= (RW'(ld_dabs) << W));
        ld_quo[l] = '0;
        ld_neg[l] = ld_csign[l] ^ ld_dsign;
      end else begin
        {ld_ovf[l], ld_quo[l]} = sat_fn(ld_cmag[l] >> FRAC_BITS, ld_csign[l]);
        ld_neg[l] = ld_csign[l];
      end
    end
  end

  // division stages, most significant quotient bit first
  always_comb begin
    for (int s = 0; s < W; s++) begin
      trial[s] = RW'(dabs[s]) << (W - 1 - s);
      for (int l = 0; l < 9; l++) begin
        nrem[s][l] = rem[s][l];
        nquo[s][l] = quo[s][l];
        if (inv[s] && (rem[s][l] >= trial[s])) begin
          nrem[s][l]        = rem[s][l] - trial[s];
          nquo[s][l][W-1-s] = 1'b1;
        end
      end
    end
  end

  // load and division stage registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= W; s++) begin
        vld[s] <= 1'b0;
      end
    end else if (en) begin
      vld[0]  <= in_valid;
      dabs[0] <= ld_dabs;
      inv[0]  <= ld_inv;
      for (int l = 0; l < 9; l++) begin
        rem[0][l] <= ld_rem[l];
        quo[0][l] <= ld_quo[l];
        ovf[0][l] <= ld_ovf[l];
        neg[0][l] <= ld_neg[l];
      end
      for (int s = 1; s <= W; s++) begin
        vld[s]  <= vld[s-1];
        dabs[s] <= dabs[s-1];
        inv[s]  <= inv[s-1];
        for (int l = 0; l < 9; l++) begin
          rem[s][l] <= nrem[s-1][l];
          quo[s][l] <= nquo[s-1][l];
          ovf[s][l] <= ovf[s-1][l];
          neg[s][l] <= neg[s-1][l];
        end
      end
    end
  end

  // saturation of quotients
  always_comb begin
    for (int l = 0; l < 9; l++) begin
      if (!inv[W]) begin
        fin_res[l] = quo[W][l];
        fin_sat[l] = ovf[W][l];
      end else if (ovf[W][l]) begin
        fin_res[l] = neg[W][l] ? MINV : MAXP;
        fin_sat[l] = 1'b1;
      end else begin
        {fin_sat[l], fin_res[l]} = sat_fn(MW'(quo[W][l]), neg[W][l]);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[W];
      inverted  <= inv[W];
      saturated <= |fin_sat;
      for (int l = 0; l < 9; l++) begin
        out_data[l*W +: W] <= fin_res[l];
      end
    end
  end

endmodule

/* hw/rtl/matrix3_inverse_adjugate.sv */
// ----------------------------------------------------------------------------
// matrix3_inverse_adjugate
// 3x3 signed fixed-point matrix inverse by adjugate and exact division.
// ----------------------------------------------------------------------------
//  channel   dir   handshake          payload
//  s_axis    in    s_tvalid/s_tready  s_tdata: nine elements, row-major
//  m_axis    out   m_tvalid/m_tready  m_tdata: nine results; m_tuser: flags
//  apb       in    psel/penable       det_threshold at address 0
//
//  One item per cycle sustained while m_tready stays high; items pass through
//  the front multiplier pipeline, the queue, the divider load stage, one
//  divider stage per quotient bit and the output register.
//  Reset clears all valid bits, the queue and det_threshold.
//  The front stalls only when the queue is full; the back stalls only when
//  the output register is held by m_tready low.
// ----------------------------------------------------------------------------
module matrix3_inverse_adjugate #(
  parameter int ELEM_WIDTH = m3inv_pkg::ELEM_WIDTH_DEF,
  parameter int FRAC_BITS  = m3inv_pkg::FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // in_r0c0, in_r0c1, ... in_r2c2 from bit 0, zero padded to bytes
  input  logic [((9*ELEM_WIDTH+7)/8)*8-1:0]      s_tdata,
  input  logic                                   s_tvalid,
  output logic                                   s_tready,
  // out_r0c0, out_r0c1, ... out_r2c2 from bit 0, zero padded to bytes
  output logic [((9*ELEM_WIDTH+7)/8)*8-1:0]      m_tdata,
  // bit 0 inverted, bit 1 saturated
  output logic [1:0]                             m_tuser,
  output logic                                   m_tvalid,
  input  logic                                   m_tready,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [m3inv_pkg::APB_ADDR_WIDTH-1:0]   paddr,
  input  logic [m3inv_pkg::APB_DATA_WIDTH-1:0]   pwdata,
  output logic [m3inv_pkg::APB_DATA_WIDTH-1:0]   prdata,
  output logic                                   pready
);
  import m3inv_pkg::*;

  localparam int TDW = ((9 * ELEM_WIDTH + 7) / 8) * 8;
  localparam int QW  = 9 * 2 * ELEM_WIDTH + 9 + 3 * ELEM_WIDTH + 2;

  logic [THR_WIDTH-1:0]      det_threshold;
  logic                      f_valid, f_ready;
  logic [QW-1:0]             f_data;
  logic                      q_valid, q_ready;
  logic [QW-1:0]             q_data;
  logic [9*ELEM_WIDTH-1:0]   b_data;
  logic                      b_inverted, b_saturated;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_DET_THRESHOLD) ? APB_DATA_WIDTH'(det_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      det_threshold <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == ADDR_DET_THRESHOLD)) begin
      det_threshold <= pwdata[THR_WIDTH-1:0];
    end
  end

  m3inv_front #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .det_threshold (det_threshold),
    .in_valid      (s_tvalid),
    .in_ready      (s_tready),
    .in_data       (s_tdata[9*ELEM_WIDTH-1:0]),
    .out_valid     (f_valid),
    .out_ready     (f_ready),
    .out_data      (f_data)
  );

  m3inv_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_data)
  );

  m3inv_back #(
    .ELEM_WIDTH (ELEM_WIDTH),
    .FRAC_BITS  (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_data   (q_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (b_data),
    .inverted  (b_inverted),
    .saturated (b_saturated)
  );

  assign m_tdata = TDW'(b_data);
  assign m_tuser = {b_saturated, b_inverted};

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 adjugate matrix inverter: streams random and
// corner-case matrices under random stalls, predicts each result with exact
// wide arithmetic and compares every field against the output stream.
// ----------------------------------------------------------------------------
module tb;
  import m3inv_pkg::*;

  localparam int EW = 32;
  localparam int FB = 16;
  localparam int DW = 9 * EW;
  localparam int LATENCY = 5 + 1 + EW + 2;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct {
    logic [DW-1:0] data;
    logic          inverted;
    logic          saturated;
  } inv_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic [DW-1:0] s_tdata = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DW-1:0] m_tdata;
  logic [1:0] m_tuser;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [APB_ADDR_WIDTH-1:0] paddr = '0;
  logic [APB_DATA_WIDTH-1:0] pwdata = '0;
  logic [APB_DATA_WIDTH-1:0] prdata;
  logic pready;

  matrix3_inverse_adjugate uut (
    .clk(clk), .rst(rst),
    .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  logic [DW-1:0]  pending_mats[$];
  inv_result_t    expected_results[$];
  logic [30:0]    det_threshold_cfg = '0;
  int             error_count = 0;
  bit             feed_pause = 1'b0;
  bit             sink_hold = 1'b0;
  int             send_gap = 0;
  int             recv_gap = 0;
  logic           s_tready_q = 1'b0;

  function automatic elem_t sat_elem(logic signed [255:0] v, inout logic sat);
    if (v > 256'sh7FFFFFFF) begin
      sat = 1'b1;
      return 32'h7FFFFFFF;
    end
    if (v < -256'sh80000000) begin
      sat = 1'b1;
      return 32'h80000000;
    end
    return v[EW-1:0];
  endfunction

  // exact cofactors, determinant, threshold test, truncating divide
  function automatic inv_result_t invert_matrix(logic [DW-1:0] packed_mat);
    logic signed [255:0] m[9];
    logic signed [255:0] cof[9];
    logic signed [255:0] det, dabs, q, cmag;
    logic [255:0] thr;
    inv_result_t r;
    logic neg;
    for (int i = 0; i < 9; i++) m[i] = $signed(packed_mat[i*EW +: EW]);
    cof[0] = m[4]*m[8] - m[5]*m[7];
    cof[1] = m[2]*m[7] - m[1]*m[8];
    cof[2] = m[1]*m[5] - m[2]*m[4];
    cof[3] = m[5]*m[6] - m[3]*m[8];
    cof[4] = m[0]*m[8] - m[2]*m[6];
    cof[5] = m[2]*m[3] - m[0]*m[5];
    cof[6] = m[3]*m[7] - m[4]*m[6];
    cof[7] = m[1]*m[6] - m[0]*m[7];
    cof[8] = m[0]*m[4] - m[1]*m[3];
    det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
    dabs = det < 0 ? -det : det;
    thr = 256'(det_threshold_cfg) << (2*FB);
    r.inverted = $unsigned(dabs) > thr;
    r.saturated = 1'b0;
    for (int i = 0; i < 9; i++) begin
      cmag = cof[i] < 0 ? -cof[i] : cof[i];
      neg = cof[i] < 0;
      if (r.inverted) begin
        q = (cmag <<< (2*FB)) / dabs;
        neg = neg ^ (det < 0);
      end else begin
        q = cmag >>> FB;
      end
      r.data[i*EW +: EW] = sat_elem(neg ? -q : q, r.saturated);
    end
    return r;
  endfunction

  function automatic elem_t rand_elem(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h3FFFF)) - 32'sh20000;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
    endcase
  endfunction

  function automatic logic [DW-1:0] rand_matrix();
    logic [DW-1:0] v;
    int mode;
    mode = $urandom_range(0, 9);
    for (int i = 0; i < 9; i++) begin
      case (mode)
        0, 1:    v[i*EW +: EW] = rand_elem(0);
        2, 3, 4: v[i*EW +: EW] = rand_elem(1);
        5, 6:    v[i*EW +: EW] = rand_elem(2);
        7:       v[i*EW +: EW] = rand_elem($urandom_range(0, 3));
        default: v[i*EW +: EW] = (i % 4 == 0) ? rand_elem(1) : rand_elem(2);
      endcase
    end
    // singular: copy one row onto another
    if ($urandom_range(0, 15) == 0) v[3*EW*$urandom_range(1, 2) +: 3*EW] = v[0 +: 3*EW];
    return v;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // sender: offers the head of the pending queue
  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready_q) begin
        if (pending_mats.size() > 0 && send_gap == 0 && !feed_pause) begin
          s_tdata <= pending_mats.pop_front();
          send_gap <= rand_gap();
        end else begin
          s_tvalid <= 1'b0;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) send_gap <= send_gap - 1;
        else if (pending_mats.size() > 0 && !feed_pause) begin
          s_tdata <= pending_mats.pop_front();
          s_tvalid <= 1'b1;
          send_gap <= rand_gap();
        end
      end
    end
  end

  // receiver ready with random gaps, or held off entirely
  always @(negedge clk) begin
    if (!rst) begin
      if (sink_hold) m_tready <= 1'b0;
      else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= rand_gap();
      end
    end
  end

  // accept at rising edges; predict inputs, check outputs
  always @(posedge clk) begin
    inv_result_t exp_r;
    s_tready_q <= 1'b0;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(invert_matrix(s_tdata));
        s_tready_q <= 1'b1;
      end
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h flags %b", $time, m_tdata, m_tuser);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          for (int i = 0; i < 9; i++)
            if (m_tdata[i*EW +: EW] !== exp_r.data[i*EW +: EW]) begin
              $display("%0t: element %0d expected %h actual %h", $time, i,
                       exp_r.data[i*EW +: EW], m_tdata[i*EW +: EW]);
              error_count++;
            end
          if (m_tuser[0] !== exp_r.inverted) begin
            $display("%0t: inverted expected %b actual %b", $time,
                     exp_r.inverted, m_tuser[0]);
            error_count++;
          end
          if (m_tuser[1] !== exp_r.saturated) begin
            $display("%0t: saturated expected %b actual %b", $time,
                     exp_r.saturated, m_tuser[1]);
            error_count++;
          end
        end
      end
    end
  end

  task automatic write_threshold(logic [30:0] value);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= ADDR_DET_THRESHOLD; pwdata <= {1'b0, value};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    det_threshold_cfg = value;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    // read back
    @(negedge clk);
    psel <= 1'b1; paddr <= ADDR_DET_THRESHOLD;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[30:0] !== value) begin
      $display("%0t: threshold readback expected %h actual %h", $time, value, prdata);
      error_count++;
    end
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_mats.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] diag_matrix(elem_t a);
    logic [DW-1:0] v = '0;
    v[0 +: EW] = a; v[4*EW +: EW] = a; v[8*EW +: EW] = a;
    return v;
  endfunction

  initial begin
    logic [30:0] thr_set[4];
    thr_set = '{31'd0, 31'd1, 31'h7FFFFFFF, 31'h00008000};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity, zero, singular, extremes, negative and tiny values
    pending_mats.push_back(diag_matrix(32'h00010000));
    pending_mats.push_back('0);
    pending_mats.push_back({9{32'h00010000}});
    pending_mats.push_back({9{32'h7FFFFFFF}});
    pending_mats.push_back({9{32'h80000000}});
    pending_mats.push_back(diag_matrix(32'h7FFFFFFF));
    pending_mats.push_back(diag_matrix(32'h80000000));
    pending_mats.push_back(diag_matrix(32'h00000001));
    pending_mats.push_back(diag_matrix(32'hFFFF0000));
    pending_mats.push_back(diag_matrix(32'h00020000));
    pending_mats.push_back({32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                            32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                            32'h7FFFFFFF, 32'h80000000, 32'h00000000});
    pending_mats.push_back({32'hFFFFFFFF, 32'h0, 32'h0, 32'h0, 32'hFFFFFFFF,
                            32'h0, 32'h0, 32'h0, 32'hFFFFFFFF});
    for (int i = 0; i < 8; i++) pending_mats.push_back(rand_matrix());
    wait_drained();

    // phases over threshold settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      write_threshold(ph < 4 ? thr_set[ph] : 31'($urandom_range(0, 32'h7FFFF)));
      for (int i = 0; i < 320; i++) pending_mats.push_back(rand_matrix());
      if (ph == 2) begin
        // long receiver hold-off while the sender keeps offering
        sink_hold = 1'b1;
        repeat (200) @(posedge clk);
        sink_hold = 1'b0;
      end
      if (ph == 4) begin
        // sender pause until every result is home
        while (pending_mats.size() > 160) @(posedge clk);
        feed_pause = 1'b1;
        while (s_tvalid || expected_results.size() > 0) @(posedge clk);
        feed_pause = 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0) $display("** matrix3_inverse_adjugate: PASSED **");
    else $display("** matrix3_inverse_adjugate: FAILED **");
    $finish;
  end

  initial begin
    #(20ns * 400000);
    $display("** matrix3_inverse_adjugate: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/m3inv_pkg.sv
hw/rtl/m3inv_front.sv
hw/rtl/m3inv_fifo.sv
hw/rtl/m3inv_back.sv
hw/rtl/matrix3_inverse_adjugate.sv
tb/tb.sv
